[sv/flr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_pkg
// Shared constants and types of the fixed-point line rasterizer.
// ----------------------------------------------------------------------------
package flr_pkg;

    localparam int DEF_COORD_BITS = 6;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int COLOR_BITS     = 8;

    // Operation select of the shared adder/subtractor.
    typedef logic t_alu_op;
    localparam t_alu_op ALU_ADD = 1'b0;
    localparam t_alu_op ALU_SUB = 1'b1;

endpackage

[sv/flr_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_alu
// Shared adder/subtractor, used for the slope division and the accumulator.
// ----------------------------------------------------------------------------
module flr_alu
    import flr_pkg::*;
#(
    parameter int W = DEF_COORD_BITS + DEF_FRAC_BITS + 1
) (
    input  t_alu_op        i_op,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [W-1:0]   o_res
);

    logic         w_sub;
    logic [W-1:0] w_b_inv;

    // One carry chain: subtraction adds the inverted operand plus one.
    assign w_sub   = (i_op == ALU_SUB);
    assign w_b_inv = i_b ^ {W{w_sub}};
    assign o_res   = i_a + w_b_inv + W'(w_sub);

endmodule

[sv/fixed_point_line_rasterizer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer_top
// DDA line rasterizer: one line request in, one pixel word per step out.
// ----------------------------------------------------------------------------
// Channel  Dir  Word contents (low bits first)
// s_axis   in   x_start, y_start, x_end, y_end, pen_color
// m_axis   out  pixel_x, pixel_y, pixel_color; tlast = last_pixel
//
// A line is taken in the idle state, then restoring division finds the slope
// (FRAC_BITS+1 quotient bits, 17 by default, skipped for a single point);
// then the sequencer emits |long|+1 pixels, one per cycle while the output
// is not stalled. Both phases run through the one shared adder. A stalled
// output holds the sequencer in place.
// The input is ready only when the sequencer is idle; the output register
// lets a new line be taken while the last pixel still waits.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer_top
    import flr_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int IN_W        = 4 * COORD_BITS + COLOR_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 2 * COORD_BITS + COLOR_BITS,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // x_start, y_start, x_end, y_end, pen_color
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int ACC_W = C + F;
    localparam int ALU_W = C + F + 1;
    localparam int CNT_W = $clog2(F + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [C-1:0]          r_len, n_len;
    logic [C:0]            r_rem, n_rem;
    logic [F:0]            r_q, n_q;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [C-1:0]          r_major, n_major;
    logic [C-1:0]          r_left, n_left;
    logic                  r_ymaj, n_ymaj;
    logic                  r_dec, n_dec;
    logic                  r_neg_short, n_neg_short;
    logic [COLOR_BITS-1:0] r_color, n_color;

    logic                  r_out_valid;
    logic [C-1:0]          r_px, r_py;
    logic [COLOR_BITS-1:0] r_pcolor;
    logic                  r_plast;

    logic [C-1:0]          w_xs, w_ys, w_xe, w_ye;
    logic [COLOR_BITS-1:0] w_color;
    logic signed [C:0]     w_dx, w_dy, w_long, w_short;
    logic [C-1:0]          w_adx, w_ady;
    logic                  w_ymaj, w_accept, w_load;
    logic [C-1:0]          w_minor;

    t_alu_op               w_op;
    logic [ALU_W-1:0]      w_a, w_b, w_res;
    logic                  w_ge;

    assign w_xs    = i_s_tdata[0 +: C];
    assign w_ys    = i_s_tdata[C +: C];
    assign w_xe    = i_s_tdata[2*C +: C];
    assign w_ye    = i_s_tdata[3*C +: C];
    assign w_color = i_s_tdata[4*C +: COLOR_BITS];

    assign w_dx    = $signed({1'b0, w_xe}) - $signed({1'b0, w_xs});
    assign w_dy    = $signed({1'b0, w_ye}) - $signed({1'b0, w_ys});
    assign w_adx   = w_dx[C] ? C'(-w_dx) : w_dx[C-1:0];
    assign w_ady   = w_dy[C] ? C'(-w_dy) : w_dy[C-1:0];
    assign w_ymaj  = (w_ady > w_adx);
    assign w_long  = w_ymaj ? w_dy : w_dx;
    assign w_short = w_ymaj ? w_dx : w_dy;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == ST_EMIT) && (!r_out_valid || i_m_tready);

    // Division compares remainder against |long|; emission steps the accumulator
    // by the slope magnitude, whose sign follows the minor difference.
    always_comb begin
        if (r_state == ST_DIV) begin
            w_op = ALU_SUB;
            w_a  = ALU_W'(r_rem);
            w_b  = ALU_W'(r_len);
        end else begin
            w_op = r_neg_short ? ALU_SUB : ALU_ADD;
            w_a  = ALU_W'(r_acc);
            w_b  = ALU_W'(r_q);
        end
    end

    flr_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    assign w_ge    = !w_res[ALU_W-1];
    assign w_minor = r_acc[F +: C];

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_rem       = r_rem;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_major     = r_major;
        n_left      = r_left;
        n_ymaj      = r_ymaj;
        n_dec       = r_dec;
        n_neg_short = r_neg_short;
        n_color     = r_color;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ymaj      = w_ymaj;
                    n_len       = w_ymaj ? w_ady : w_adx;
                    n_left      = w_ymaj ? w_ady : w_adx;
                    n_rem       = {1'b0, (w_ymaj ? w_adx : w_ady)};
                    n_dec       = w_long[C];
                    n_neg_short = w_short[C];
                    n_major     = w_ymaj ? w_ys : w_xs;
                    n_acc       = {(w_ymaj ? w_xs : w_ys), 1'b1, {(F-1){1'b0}}};
                    n_color     = w_color;
                    n_q         = '0;
                    n_cnt       = CNT_W'(F);
                    n_state     = (w_long == '0) ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                n_q   = {r_q[F-1:0], w_ge};
                n_rem = {(w_ge ? w_res[C-1:0] : r_rem[C-1:0]), 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_acc   = w_res[ACC_W-1:0];
                    n_major = r_dec ? (r_major - C'(1)) : (r_major + C'(1));
                    n_left  = r_left - C'(1);
                    if (r_left == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_cnt       <= n_cnt;
        r_acc       <= n_acc;
        r_major     <= n_major;
        r_left      <= n_left;
        r_ymaj      <= n_ymaj;
        r_dec       <= n_dec;
        r_neg_short <= n_neg_short;
        r_color     <= n_color;
        if (w_load) begin
            r_px     <= r_ymaj ? w_minor : r_major;
            r_py     <= r_ymaj ? r_major : w_minor;
            r_pcolor <= r_color;
            r_plast  <= (r_left == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_pcolor, r_py, r_px});
    assign o_m_tlast  = r_plast;

`ifndef NO_ASSERTIONS
    // A single-point line skips the divider.
    a_point_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_xs == w_xe && w_ys == w_ye) |=> (r_state == ST_EMIT))
        else $error("single-point line entered the divider");

    // The slope magnitude never exceeds one whole unit.
    a_slope_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == '0) |=> (r_q <= (F+1)'(1) << F))
        else $error("slope quotient out of range");

    // The final pixel loaded returns the sequencer to idle with tlast set.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_left == '0) |=> (r_state == ST_IDLE && o_m_tlast && o_m_tvalid))
        else $error("final pixel did not close the line");
`endif

endmodule
